>>> design/decimal_digit_blanking_renderer_defines.svh
// Assertion macros shared by the decimal digit blanking renderer.
`ifndef DECIMAL_DIGIT_BLANKING_RENDERER_DEFINES_SVH
`define DECIMAL_DIGIT_BLANKING_RENDERER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and quiet during reset.
`define DDBR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on aclk and quiet during reset.
`define DDBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> design/ddbr_pkg.sv
// Types and constants shared by the decimal digit blanking renderer.
`default_nettype none

package ddbr_pkg;

    localparam int VALUE_W = 32;
    localparam int ADDR_W  = 4;
    localparam int CODE_W  = 4;

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'hF;
    localparam logic [ADDR_W-1:0] FIRST_REG  = 4'h1;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } head_t;

endpackage

`default_nettype wire

>>> design/decimal_digit_blanking_renderer.sv
// Decimal digit renderer: 32-bit value in, one digit register write per position out.
//
// The slave channel takes one unsigned 32-bit value per item on s_tdata.
// For each value the master channel gives DIGITS items, one per digit
// position from register 1 (least significant) up to register DIGITS.
// Each item carries the register address and either a digit 0 to 9 or the
// blank code 15; positions above the most significant nonzero digit are
// blank, zero shows a single 0, and digits beyond DIGITS are dropped.
// m_tlast marks the write for the highest position.
// Path: with the queue empty, the first write of a value goes through the queue
// entry and then the output register. Throughput is one output item per cycle
// while the output does not stall, from the single divide-by-ten step that
// produces one digit each cycle.
// A two-entry queue sits between the input and the digit engine, so the
// input keeps accepting while a write waits on the output register.
// When m_tready is low the output register holds and the engine stalls;
// s_tready drops once the queue is full.
// Reset (aresetn low, synchronous) empties the queue and the output register.
`default_nettype none

`include "decimal_digit_blanking_renderer_defines.svh"

module decimal_digit_blanking_renderer #(
    parameter int DIGITS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] register_address, [7:4] digit_code
    output logic             m_tlast
);

    ddbr_pkg::head_t             head;
    logic                        pop;
    logic [ddbr_pkg::ADDR_W-1:0] out_addr;
    logic [ddbr_pkg::CODE_W-1:0] out_code;
    logic                        out_first;
    logic                        out_blank;

    ddbr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .pop      (pop)
    );

    ddbr_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign out_addr  = m_tdata[3:0];
    assign out_code  = m_tdata[7:4];
    assign out_first = (out_addr == ddbr_pkg::FIRST_REG);
    assign out_blank = (out_code == ddbr_pkg::BLANK_CODE);

    `DDBR_ASSERT_IMPL(a_last_addr, m_tvalid && m_tlast, out_addr == 4'(DIGITS))
    `DDBR_ASSERT_IMPL(a_first_not_blank, m_tvalid && out_first, !out_blank)
    `DDBR_ASSERT_IMPL(a_code_range, m_tvalid, (out_code <= 4'd9) || out_blank)
    `DDBR_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

`default_nettype wire

>>> design/ddbr_front.sv
// Front end: accepts input items into a short queue ahead of the digit engine.
`default_nettype none

module ddbr_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ddbr_pkg::VALUE_W-1:0] s_tdata,
    output ddbr_pkg::head_t                  head,
    input  wire logic                        pop
);

    logic [ddbr_pkg::VALUE_W-1:0] entry_reg [ddbr_pkg::QUEUE_DEPTH];
    logic [ddbr_pkg::PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ddbr_pkg::PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ddbr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         push;
    logic                         do_pop;

    always_comb begin
        s_tready   = (count_reg != ddbr_pkg::CNT_W'(ddbr_pkg::QUEUE_DEPTH));
        push       = s_tvalid && s_tready;
        do_pop     = pop && (count_reg != '0);
        head.valid = (count_reg != '0);
        head.value = entry_reg[rd_ptr_reg];

        wr_ptr_next = push   ? wr_ptr_reg + ddbr_pkg::PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + ddbr_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + ddbr_pkg::CNT_W'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - ddbr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_tdata;
        end
    end

endmodule

`default_nettype wire

>>> design/ddbr_back.sv
// Back end: peels off one decimal digit per cycle unless the output stalls, and drives the output register.
`default_nettype none

module ddbr_back #(
    parameter int DIGITS = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ddbr_pkg::head_t            head,
    output logic                            pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast
);

    localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic                          busy_reg, busy_next;
    logic [PW-1:0]                 pos_reg, pos_next;
    logic [ddbr_pkg::VALUE_W-1:0]  rest_reg, rest_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ddbr_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [ddbr_pkg::CODE_W-1:0]   code_reg, code_next;
    logic                          last_reg, last_next;

    logic                          out_ready;
    logic                          step;
    logic [ddbr_pkg::VALUE_W-1:0]  cur;
    logic [PW-1:0]                 pos;
    logic [2*ddbr_pkg::VALUE_W-1:0] prod;
    logic [ddbr_pkg::VALUE_W-1:0]  quot;
    logic [ddbr_pkg::VALUE_W-1:0]  rem_full;
    logic                          is_last;

    always_comb begin
        out_ready = !m_valid_reg || m_tready;
        step      = out_ready && (busy_reg || head.valid);
        pop       = step && !busy_reg;
        cur       = busy_reg ? rest_reg : head.value;
        pos       = busy_reg ? pos_reg : '0;

        // Divide by ten through the reciprocal; the remainder falls out of x - 10q.
        prod     = {{ddbr_pkg::VALUE_W{1'b0}}, cur}
                 * {{ddbr_pkg::VALUE_W{1'b0}}, ddbr_pkg::RECIP_10};
        quot     = ddbr_pkg::VALUE_W'(prod >> ddbr_pkg::RECIP_SHIFT);
        rem_full = cur - ((quot << 3) + (quot << 1));
        is_last  = (pos == PW'(DIGITS - 1));

        busy_next    = busy_reg;
        pos_next     = pos_reg;
        rest_next    = rest_reg;
        m_valid_next = m_valid_reg;
        addr_next    = addr_reg;
        code_next    = code_reg;
        last_next    = last_reg;

        if (out_ready) begin
            m_valid_next = step;
        end
        if (step) begin
            busy_next = !is_last;
            pos_next  = pos + PW'(1);
            rest_next = quot;
            addr_next = ddbr_pkg::ADDR_W'(pos) + ddbr_pkg::FIRST_REG;
            // The lowest position always shows a digit, even for zero.
            code_next = ((pos == '0) || (cur != '0)) ? rem_full[ddbr_pkg::CODE_W-1:0]
                                                    : ddbr_pkg::BLANK_CODE;
            last_next = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        rest_reg <= rest_next;
        addr_reg <= addr_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {code_reg, addr_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire
